// ----- hdl/deadline_job_sequencer_defines.svh -----
// ---------------------------------------------------------------------------
// deadline_job_sequencer_defines
// assertion macros shared by the checker
// ---------------------------------------------------------------------------
`ifndef DEADLINE_JOB_SEQUENCER_DEFINES_SVH
`define DEADLINE_JOB_SEQUENCER_DEFINES_SVH

// same-cycle implication under reset
`define DLJS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dljs same-cycle check failed");

// next-cycle implication under reset
`define DLJS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dljs next-cycle check failed");

`endif

// ----- hdl/dljs_pkg.sv -----
// ---------------------------------------------------------------------------
// dljs_pkg
// shared types and constants of the deadline job sequencer
// ---------------------------------------------------------------------------
package dljs_pkg;

  localparam int MAX_JOBS  = 32;
  localparam int MAX_SLOTS = 16;
  localparam int JOB_AW    = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int SLOT_W    = 5;

  localparam logic CFG_NUM_SLOTS = 1'b0;
  localparam logic CFG_DERIVE    = 1'b1;

  typedef struct packed {
    logic [15:0]        tag;
    logic [15:0]        pri;
    logic signed [15:0] dl;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_PLACE,
    ST_FLUSH
  } state_t;

endpackage

// ----- hdl/dljs_store.sv -----
// ---------------------------------------------------------------------------
// dljs_store
// job store, one write port and one registered read port
// ---------------------------------------------------------------------------
module dljs_store
  import dljs_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [JOB_AW-1:0] waddr,
  input  job_t              wdata,
  input  logic [JOB_AW-1:0] raddr,
  output job_t              rdata
);

  job_t mem [MAX_JOBS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dljs_modu.sv -----
// ---------------------------------------------------------------------------
// dljs_modu
// bit-serial remainder of a 16-bit value by the slot count
// ---------------------------------------------------------------------------
module dljs_modu
  import dljs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       dividend,
  input  logic [SLOT_W-1:0] divisor,
  output logic              done,
  output logic [SLOT_W-1:0] rem
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [15:0]       dvd_r, dvd_nxt;
  logic [SLOT_W:0]   trial;

  // one dividend bit per cycle, compare and subtract
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    trial    = {rem_r, dvd_r[15]};
    if (start) begin
      run_nxt = 1'b1;
      bit_nxt = '0;
      rem_nxt = '0;
      dvd_nxt = dividend;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[SLOT_W-1:0];
      dvd_nxt = {dvd_r[14:0], 1'b0};
      bit_nxt = bit_r + 4'd1;
      if (bit_r == 4'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hdl/deadline_job_sequencer.sv -----
// ---------------------------------------------------------------------------
// deadline_job_sequencer
// greedy job sequencing with deadlines over a stored job set
// ---------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  input    | in_job_tag .. in_last_job    | start high, busy low
//  result   | out_tag .. out_last_result   | out_valid strobe, one cycle
//  config   | cfg_we, cfg_index, cfg_wdata | cfg_we high
//
// A job that does not end the set is only stored. The job that ends the
// set starts a schedule: each stored job, placed or dropped, costs one scan
// of the store through the single read port, a serial remainder in derive
// mode, and one placement step; the closing scan and a flush step end it.
// busy stays high for the whole schedule. Reset is synchronous; the
// receiver cannot stall results.
module deadline_job_sequencer
  import dljs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_job_tag,
  input  logic [15:0]        in_priority_req,
  input  logic signed [15:0] in_deadline,
  input  logic               in_last_job,
  output logic               out_valid,
  output logic [15:0]        out_tag,
  output logic [15:0]        out_priority,
  output logic signed [15:0] out_deadline,
  output logic [SLOT_W-1:0]  out_slot_number,
  output logic               out_none_placed,
  output logic               out_overflow,
  output logic               out_last_result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [4:0]        num_slots_r;
  logic              derive_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              ovf_r, ovf_nxt;
  logic [MAX_SLOTS-1:0] map_r, map_nxt;
  logic [MAX_JOBS-1:0]  used_r, used_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [JOB_AW-1:0] rd_addr_r, rd_addr_nxt;
  logic              found_r, found_nxt;
  logic [JOB_AW-1:0] best_idx_r, best_idx_nxt;
  job_t              best_r, best_nxt;
  logic signed [15:0] eff_r, eff_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  job_t              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;

  logic              ov_r, ov_nxt;
  job_t              ojob_r, ojob_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  logic              onone_r, onone_nxt;
  logic              olast_r, olast_nxt;
  logic              oovf_r, oovf_nxt;

  logic              accept;
  logic              st_we;
  job_t              st_wdata;
  logic [JOB_AW-1:0] st_raddr;
  job_t              st_rdata;
  logic [SLOT_W-1:0] slots;
  logic              mod_start;
  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;
  logic [SLOT_W-1:0] lim;
  logic              lim_ok;
  logic              free_hit;
  logic [SLOT_W-1:0] free_pos;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // effective slot count, zero acts as one, clamp at the maximum
  always_comb begin
    if (num_slots_r == '0) begin
      slots = SLOT_W'(1);
    end else if (num_slots_r > SLOT_W'(MAX_SLOTS)) begin
      slots = SLOT_W'(MAX_SLOTS);
    end else begin
      slots = num_slots_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_slots_r <= 5'd16;
      derive_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_SLOTS: num_slots_r <= cfg_wdata;
        CFG_DERIVE:    derive_r    <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  // job store
  assign st_we    = accept && (cnt_r < CNT_W'(MAX_JOBS));
  assign st_wdata = '{tag: in_job_tag, pri: in_priority_req, dl: in_deadline};
  assign st_raddr = iss_r[JOB_AW-1:0];

  dljs_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt_r[JOB_AW-1:0]),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  dljs_modu u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (best_r.pri),
    .divisor  (slots),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // placement limit and latest free slot below it
  always_comb begin
    lim_ok = (eff_r > 16'sd0);
    if (eff_r > $signed({11'b0, slots})) begin
      lim = slots;
    end else begin
      lim = eff_r[SLOT_W-1:0];
    end
    free_hit = 1'b0;
    free_pos = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (lim_ok && (SLOT_W'(s) < lim) && !map_r[s]) begin
        free_hit = 1'b1;
        free_pos = SLOT_W'(s);
      end
    end
  end

  // sequencer next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    ovf_nxt       = ovf_r;
    map_nxt       = map_r;
    used_nxt      = used_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    eff_nxt       = eff_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    mod_start     = 1'b0;
    ov_nxt        = 1'b0;
    ojob_nxt      = ojob_r;
    oslot_nxt     = oslot_r;
    onone_nxt     = 1'b0;
    olast_nxt     = 1'b0;
    oovf_nxt      = ovf_r;

    case (state_r)
      // load beats, last job starts the schedule
      ST_IDLE: begin
        if (accept) begin
          if (st_we) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_job) begin
            n_nxt     = st_we ? cnt_r + CNT_W'(1) : cnt_r;
            iss_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end

      // walk the store for the highest unused priority, first on ties
      ST_SCAN: begin
        if (iss_r < n_r) begin
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = iss_r[JOB_AW-1:0];
          iss_nxt     = iss_r + CNT_W'(1);
        end
        if (rd_vld_r && !used_r[rd_addr_r] &&
            (!found_r || (st_rdata.pri > best_r.pri))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_addr_r;
          best_nxt     = st_rdata;
        end
        if ((iss_r == n_r) && !rd_vld_r) begin
          if (!found_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            used_nxt[best_idx_r] = 1'b1;
            if (derive_r) begin
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end else begin
              eff_nxt   = best_r.dl;
              state_nxt = ST_PLACE;
            end
          end
        end
      end

      // derived deadline from the remainder
      ST_MOD: begin
        if (mod_done) begin
          eff_nxt   = 16'(slots - mod_rem);
          state_nxt = ST_PLACE;
        end
      end

      // take the latest free slot, hold the beat back one placement
      ST_PLACE: begin
        if (free_hit) begin
          map_nxt[free_pos[$clog2(MAX_SLOTS)-1:0]] = 1'b1;
          if (pend_vld_r) begin
            ov_nxt    = 1'b1;
            ojob_nxt  = pend_r;
            oslot_nxt = pend_slot_r;
          end
          pend_vld_nxt  = 1'b1;
          pend_nxt      = '{tag: best_r.tag, pri: best_r.pri, dl: eff_r};
          pend_slot_nxt = free_pos + SLOT_W'(1);
        end
        iss_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end

      // final beat, then clear the set
      ST_FLUSH: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (pend_vld_r) begin
          ojob_nxt  = pend_r;
          oslot_nxt = pend_slot_r;
        end else begin
          ojob_nxt  = '0;
          oslot_nxt = '0;
          onone_nxt = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        cnt_nxt      = '0;
        ovf_nxt      = 1'b0;
        map_nxt      = '0;
        used_nxt     = '0;
        state_nxt    = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      map_r      <= '0;
      used_r     <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      map_r      <= map_nxt;
      used_r     <= used_nxt;
      rd_vld_r   <= rd_vld_nxt;
      found_r    <= found_nxt;
      pend_vld_r <= pend_vld_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    iss_r       <= iss_nxt;
    rd_addr_r   <= rd_addr_nxt;
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    eff_r       <= eff_nxt;
    pend_r      <= pend_nxt;
    pend_slot_r <= pend_slot_nxt;
    ojob_r      <= ojob_nxt;
    oslot_r     <= oslot_nxt;
    onone_r     <= onone_nxt;
    olast_r     <= olast_nxt;
    oovf_r      <= oovf_nxt;
  end

  // result beat
  assign out_valid       = ov_r;
  assign out_tag         = ojob_r.tag;
  assign out_priority    = ojob_r.pri;
  assign out_deadline    = ojob_r.dl;
  assign out_slot_number = oslot_r;
  assign out_none_placed = onone_r;
  assign out_overflow    = oovf_r;
  assign out_last_result = olast_r;

endmodule

// ----- hdl/dljs_checker.sv -----
// ---------------------------------------------------------------------------
// dljs_checker
// port-level checks of the deadline job sequencer
// ---------------------------------------------------------------------------
`include "deadline_job_sequencer_defines.svh"

module dljs_checker
  import dljs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_last_job,
  input logic              out_valid,
  input logic [SLOT_W-1:0] out_slot_number,
  input logic              out_none_placed,
  input logic              out_last_result
);

  // an empty schedule is a single closing beat
  `DLJS_ASSERT_SAME(a_none_last, out_valid && out_none_placed, out_last_result)
  // slot zero only when nothing was placed
  `DLJS_ASSERT_SAME(a_none_slot, out_valid && out_none_placed, out_slot_number == '0)
  `DLJS_ASSERT_SAME(a_placed_slot, out_valid && !out_none_placed,
                    out_slot_number != '0)
  // the closing beat comes out with the block already free
  `DLJS_ASSERT_SAME(a_last_idle, out_valid && out_last_result, !busy)
  // a closing job starts the schedule
  `DLJS_ASSERT_NEXT(a_sched_busy, start && !busy && in_last_job, busy)

endmodule

bind deadline_job_sequencer dljs_checker u_dljs_checker (.*);
